FILE: hdl/vfsg_pkg.sv
// ----------------------------------------------------------------------------
// vfsg_pkg
// Shared types and codes of the vector font stroke generator.
// ----------------------------------------------------------------------------
package vfsg_pkg;

   // glyph table geometry
   localparam int TABLE_WORDS = 8192;
   localparam int TABLE_AW    = 13;

   // request opcodes
   localparam logic [1:0] OP_WRITE  = 2'd0;
   localparam logic [1:0] OP_CURSOR = 2'd1;
   localparam logic [1:0] OP_DRAW   = 2'd2;

   // result status codes
   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_NONPRINT = 2'd1;
   localparam logic [1:0] STAT_SPECIAL  = 2'd2;
   localparam logic [1:0] STAT_TRUNC    = 2'd3;

   // register indexes
   localparam logic [1:0] CSR_ROT_COS = 2'd0;
   localparam logic [1:0] CSR_ROT_SIN = 2'd1;
   localparam logic [1:0] CSR_ASPECT  = 2'd2;
   localparam logic [1:0] CSR_PEN     = 2'd3;

   // response queue
   localparam int RSP_DEPTH = 8;
   localparam int RSP_PTR_W = 3;
   localparam int RSP_CNT_W = 4;

   localparam logic [7:0] CHAR_FIRST = 8'd32;
   localparam logic [7:0] CHAR_LAST  = 8'd126;

   typedef enum logic [3:0] {
      SEQ_IDLE,
      SEQ_HEAD,
      SEQ_OFS,
      SEQ_BASE,
      SEQ_FIRST,
      SEQ_CHECK,
      SEQ_VEC,
      SEQ_ADV,
      SEQ_DRAIN
   } seq_state_type;

   // one beat into the transform pipeline
   typedef struct packed {
      logic signed [8:0] ix;
      logic signed [8:0] iy;
      logic              pen_draw;
      logic              is_final;
      logic [1:0]        status;
      logic              last;
      logic              pass;
   } beat_type;

   // one result beat
   typedef struct packed {
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic               pen_draw;
      logic               is_final;
      logic [1:0]         status;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic                 idle;
      logic [RSP_CNT_W-1:0] inflight;
   } seq_stat_type;

endpackage

FILE: hdl/vector_font_stroke_generator_top.sv
// ----------------------------------------------------------------------------
// vector_font_stroke_generator_top
// Stroke font engine: glyph table, draw sequencer and point transform.
// ----------------------------------------------------------------------------
// Requests arrive on req_* with valid/stall; one beat is one operation.
// A table write or cursor load leaves req_stall low. A draw of a printable
// glyph with pen enabled holds req_stall through two header reads, a read
// of the first vector word for the special-glyph check, one table read per
// vector through the single memory read port, then the advance beat and a
// 5-stage transform drain. A special glyph skips the vector reads, a draw
// with pen disabled reads only the first header word, and a non-printable
// code reads no table word. Only one draw is in work at a time; req_stall
// stays high until its last result has left the pipeline.
// Results leave on rsp_* through an 8-deep queue. When rsp_stall holds, the
// queue fills and the sequencer stops issuing table reads; nothing is dropped.
// The csr_* port writes rotation, aspect and pen registers; the user must
// write them only while idle, which the block itself does not enforce.
// Reset clears the cursor and registers to their defaults; the glyph table
// keeps no reset value and must be written before use.
// ----------------------------------------------------------------------------
module vector_font_stroke_generator_top #(
   parameter int MAX_VECTORS = 63
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_op,
   input  logic [12:0]        req_table_addr,
   input  logic [15:0]        req_table_data,
   input  logic [7:0]         req_char_code,
   input  logic signed [31:0] req_new_x,
   input  logic signed [31:0] req_new_y,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_point_x,
   output logic signed [31:0] rsp_point_y,
   output logic               rsp_pen_draw,
   output logic               rsp_is_final,
   output logic [1:0]         rsp_status,
   output logic               rsp_last,
   input  logic               csr_write,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_wdata
);
   import vfsg_pkg::*;

   logic signed [31:0]    rot_cos_ff, rot_sin_ff;
   logic [15:0]           aspect_ff;
   logic                  pen_ff;

   logic                  req_accept;
   logic                  mem_wr;
   logic                  beat_valid;
   beat_type              beat;
   seq_stat_type          seq_stat;
   logic                  xf_valid;
   rsp_type               xf_res;
   logic                  rsp_pop;
   rsp_type               head;
   logic [RSP_CNT_W-1:0]  fifo_count;

   always_ff @(posedge clock) begin
      if (reset) begin
         rot_cos_ff <= '0;
         rot_sin_ff <= '0;
         aspect_ff  <= 16'd4096;
         pen_ff     <= 1'b1;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_ROT_COS: rot_cos_ff <= csr_wdata;
            CSR_ROT_SIN: rot_sin_ff <= csr_wdata;
            CSR_ASPECT:  aspect_ff  <= csr_wdata[15:0];
            CSR_PEN:     pen_ff     <= csr_wdata[0];
            default:     pen_ff     <= pen_ff;
         endcase
      end
   end

   assign req_stall  = !seq_stat.idle;
   assign req_accept = req_valid && !req_stall;
   assign mem_wr     = req_accept && (req_op == OP_WRITE);

   vfsg_seq #(
      .MAX_VECTORS (MAX_VECTORS)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .mem_wr      (mem_wr),
      .mem_wr_addr (req_table_addr),
      .mem_wr_data (req_table_data),
      .start       (req_accept && (req_op == OP_DRAW)),
      .char_code   (req_char_code),
      .pen_enable  (pen_ff),
      .fifo_count  (fifo_count),
      .res_push    (xf_valid),
      .beat_valid  (beat_valid),
      .beat        (beat),
      .stat        (seq_stat)
   );

   vfsg_xform u_xform (
      .clock        (clock),
      .reset        (reset),
      .beat_valid   (beat_valid),
      .beat         (beat),
      .rot_cos      (rot_cos_ff),
      .rot_sin      (rot_sin_ff),
      .aspect_ratio (aspect_ff),
      .cur_load     (req_accept && (req_op == OP_CURSOR)),
      .new_x        (req_new_x),
      .new_y        (req_new_y),
      .res_valid    (xf_valid),
      .res          (xf_res)
   );

   assign rsp_pop = rsp_valid && !rsp_stall;

   vfsg_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (xf_valid),
      .push_data  (xf_res),
      .pop        (rsp_pop),
      .head_valid (rsp_valid),
      .head       (head),
      .count      (fifo_count)
   );

   assign rsp_point_x  = head.point_x;
   assign rsp_point_y  = head.point_y;
   assign rsp_pen_draw = head.pen_draw;
   assign rsp_is_final = head.is_final;
   assign rsp_status   = head.status;
   assign rsp_last     = head.last;

   // credit scheme must keep the queue from overflowing
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      xf_valid |-> (fifo_count < RSP_CNT_W'(RSP_DEPTH)))
      else $error("result queue overflow");

   // a new request is only taken with the pipeline empty
   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      req_accept |-> (seq_stat.inflight == '0))
      else $error("request taken with beats in flight");

   // a closing report always ends its draw
   a_final_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_final) |-> rsp_last)
      else $error("closing report not marked last");

endmodule

FILE: hdl/vfsg_seq.sv
// ----------------------------------------------------------------------------
// vfsg_seq
// Glyph table memory and the draw sequencer that walks it.
// ----------------------------------------------------------------------------
module vfsg_seq #(
   parameter int MAX_VECTORS = 63
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           mem_wr,
   input  logic [vfsg_pkg::TABLE_AW-1:0]  mem_wr_addr,
   input  logic [15:0]                    mem_wr_data,
   input  logic                           start,
   input  logic [7:0]                     char_code,
   input  logic                           pen_enable,
   input  logic [vfsg_pkg::RSP_CNT_W-1:0] fifo_count,
   input  logic                           res_push,
   output logic                           beat_valid,
   output vfsg_pkg::beat_type             beat,
   output vfsg_pkg::seq_stat_type         stat
);
   import vfsg_pkg::*;

   logic [15:0] mem [TABLE_WORDS];
   logic [15:0] rd_data_ff;

   seq_state_type state_ff, state_in;
   logic [7:0]            code_ff, code_in;
   logic [7:0]            gap_ff, gap_in;
   logic [7:0]            nvec_ff, nvec_in;
   logic [5:0]            cnt_ff, cnt_in;
   logic [5:0]            k_ff, k_in;
   logic                  trunc_ff, trunc_in;
   logic [TABLE_AW-1:0]   ptr_ff, ptr_in;
   logic                  vec_pend_ff, vec_pend_in;
   logic [RSP_CNT_W-1:0]  inflight_ff, inflight_in;

   logic                  rd_en;
   logic [TABLE_AW-1:0]   rd_addr;
   logic                  dir_valid;
   beat_type              dir_beat;
   beat_type              vec_beat;
   logic                  credit;
   logic                  printable;
   logic [TABLE_AW-1:0]   hidx;
   logic [TABLE_AW-1:0]   ptr_inc;
   logic                  special;

   always_ff @(posedge clock) begin
      if (mem_wr) begin
         mem[mem_wr_addr] <= mem_wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign credit    = ({1'b0, fifo_count} + {1'b0, inflight_ff})
                      < (RSP_CNT_W + 1)'(RSP_DEPTH);
   assign printable = (code_ff >= CHAR_FIRST) && (code_ff <= CHAR_LAST);
   assign hidx      = TABLE_AW'({code_ff - CHAR_FIRST, 1'b0});
   assign ptr_inc   = (ptr_ff == TABLE_AW'(TABLE_WORDS - 1)) ? '0 : ptr_ff + 1'b1;
   assign special   = rd_data_ff[15] | ~rd_data_ff[14];

   always_comb begin
      vec_beat.ix       = {{2{rd_data_ff[13]}}, rd_data_ff[13:7]};
      vec_beat.iy       = {{2{rd_data_ff[6]}}, rd_data_ff[6:0]};
      vec_beat.pen_draw = ~rd_data_ff[14];
      vec_beat.is_final = 1'b0;
      vec_beat.status   = STAT_OK;
      vec_beat.last     = 1'b0;
      vec_beat.pass     = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= SEQ_IDLE;
         vec_pend_ff <= 1'b0;
         inflight_ff <= '0;
      end else begin
         state_ff    <= state_in;
         vec_pend_ff <= vec_pend_in;
         inflight_ff <= inflight_in;
      end
      code_ff  <= code_in;
      gap_ff   <= gap_in;
      nvec_ff  <= nvec_in;
      cnt_ff   <= cnt_in;
      k_ff     <= k_in;
      trunc_ff <= trunc_in;
      ptr_ff   <= ptr_in;
   end

   always_comb begin
      state_in    = state_ff;
      code_in     = code_ff;
      gap_in      = gap_ff;
      nvec_in     = nvec_ff;
      cnt_in      = cnt_ff;
      k_in        = k_ff;
      trunc_in    = trunc_ff;
      ptr_in      = ptr_ff;
      vec_pend_in = 1'b0;
      rd_en       = 1'b0;
      rd_addr     = ptr_ff;
      dir_valid   = 1'b0;
      dir_beat    = '0;

      unique case (state_ff)
         SEQ_IDLE: begin
            if (start) begin
               code_in  = char_code;
               state_in = SEQ_HEAD;
            end
         end
         SEQ_HEAD: begin
            trunc_in = 1'b0;
            if (!printable) begin
               if (credit) begin
                  dir_valid       = 1'b1;
                  dir_beat.pass   = 1'b1;
                  dir_beat.status = STAT_NONPRINT;
                  dir_beat.last   = 1'b1;
                  state_in        = SEQ_DRAIN;
               end
            end else begin
               rd_en    = 1'b1;
               rd_addr  = hidx;
               state_in = SEQ_OFS;
            end
         end
         SEQ_OFS: begin
            nvec_in = rd_data_ff[7:0];
            gap_in  = rd_data_ff[15:8];
            if (pen_enable) begin
               rd_en    = 1'b1;
               rd_addr  = hidx + 1'b1;
               state_in = SEQ_BASE;
            end else begin
               state_in = SEQ_ADV;
            end
         end
         SEQ_BASE: begin
            // low bits of the signed offset are its residue in the table
            ptr_in   = rd_data_ff[TABLE_AW-1:0];
            state_in = SEQ_FIRST;
         end
         SEQ_FIRST: begin
            rd_en    = 1'b1;
            state_in = SEQ_CHECK;
         end
         SEQ_CHECK: begin
            if (special) begin
               if (credit) begin
                  dir_valid       = 1'b1;
                  dir_beat.pass   = 1'b1;
                  dir_beat.status = STAT_SPECIAL;
                  dir_beat.last   = 1'b1;
                  state_in        = SEQ_DRAIN;
               end
            end else begin
               if (nvec_ff > 8'(MAX_VECTORS)) begin
                  cnt_in   = 6'(MAX_VECTORS);
                  trunc_in = 1'b1;
               end else begin
                  cnt_in = nvec_ff[5:0];
               end
               k_in     = '0;
               state_in = SEQ_VEC;
            end
         end
         SEQ_VEC: begin
            if (k_ff == cnt_ff) begin
               state_in = SEQ_ADV;
            end else if (credit) begin
               rd_en       = 1'b1;
               ptr_in      = ptr_inc;
               k_in        = k_ff + 1'b1;
               vec_pend_in = 1'b1;
            end
         end
         SEQ_ADV: begin
            // advance rides the pipeline as a vector of (gap, 0)
            if (credit && !vec_pend_ff) begin
               dir_valid         = 1'b1;
               dir_beat.ix       = {1'b0, gap_ff};
               dir_beat.is_final = 1'b1;
               dir_beat.status   = trunc_ff ? STAT_TRUNC : STAT_OK;
               dir_beat.last     = 1'b1;
               state_in          = SEQ_DRAIN;
            end
         end
         SEQ_DRAIN: begin
            if (inflight_ff == '0) begin
               state_in = SEQ_IDLE;
            end
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase

      inflight_in = inflight_ff + RSP_CNT_W'(vec_pend_in | dir_valid)
                    - RSP_CNT_W'(res_push);
   end

   assign beat_valid    = vec_pend_ff | dir_valid;
   assign beat          = vec_pend_ff ? vec_beat : dir_beat;
   assign stat.idle     = (state_ff == SEQ_IDLE);
   assign stat.inflight = inflight_ff;

endmodule

FILE: hdl/vfsg_xform.sv
// ----------------------------------------------------------------------------
// vfsg_xform
// Rotate, scale, round and offset pipeline; owns the pen cursor.
// ----------------------------------------------------------------------------
module vfsg_xform (
   input  logic               clock,
   input  logic               reset,
   input  logic               beat_valid,
   input  vfsg_pkg::beat_type beat,
   input  logic signed [31:0] rot_cos,
   input  logic signed [31:0] rot_sin,
   input  logic [15:0]        aspect_ratio,
   input  logic               cur_load,
   input  logic signed [31:0] new_x,
   input  logic signed [31:0] new_y,
   output logic               res_valid,
   output vfsg_pkg::rsp_type  res
);
   import vfsg_pkg::*;

   function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
      logic signed [31:0] r;
      if (v > 48'sh0000_7fff_ffff) begin
         r = 32'sh7fff_ffff;
      end else if (v < -48'sh0000_8000_0000) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   logic                v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   beat_type            b1_ff, b2_ff, b3_ff, b4_ff;
   logic signed [40:0]  p_xc_ff, p_ys_ff, p_xs_ff, p_yc_ff;
   logic signed [41:0]  tx2_ff, typ2_ff, tx3_ff;
   logic signed [58:0]  ty3_ff;
   logic signed [41:0]  rx4_ff;
   logic signed [46:0]  ry4_ff;
   rsp_type             res_ff, res_in;
   logic signed [31:0]  cur_x_ff, cur_y_ff;

   logic signed [42:0]  tx_r;
   logic signed [59:0]  ty_r;
   logic signed [31:0]  sx, sy;

   assign tx_r = 43'(tx3_ff) + 43'sd1;
   assign ty_r = 60'(ty3_ff) + 60'sd4096;
   assign sx   = sat32(48'(cur_x_ff) + 48'(rx4_ff));
   assign sy   = sat32(48'(cur_y_ff) + 48'(ry4_ff));

   always_comb begin
      res_in.pen_draw = b4_ff.pen_draw;
      res_in.is_final = b4_ff.is_final;
      res_in.status   = b4_ff.status;
      res_in.last     = b4_ff.last;
      if (b4_ff.pass) begin
         res_in.point_x = cur_x_ff;
         res_in.point_y = cur_y_ff;
      end else begin
         res_in.point_x = sx;
         res_in.point_y = sy;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         v4_ff    <= 1'b0;
         v5_ff    <= 1'b0;
         cur_x_ff <= '0;
         cur_y_ff <= '0;
      end else begin
         v1_ff <= beat_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         if (cur_load) begin
            cur_x_ff <= new_x;
            cur_y_ff <= new_y;
         end else if (v4_ff && b4_ff.is_final) begin
            // the closing report moves the cursor
            cur_x_ff <= sx;
            cur_y_ff <= sy;
         end
      end
      b1_ff   <= beat;
      p_xc_ff <= 41'(beat.ix) * 41'(rot_cos);
      p_ys_ff <= 41'(beat.iy) * 41'(rot_sin);
      p_xs_ff <= 41'(beat.ix) * 41'(rot_sin);
      p_yc_ff <= 41'(beat.iy) * 41'(rot_cos);
      b2_ff   <= b1_ff;
      tx2_ff  <= 42'(p_xc_ff) - 42'(p_ys_ff);
      typ2_ff <= 42'(p_xs_ff) + 42'(p_yc_ff);
      b3_ff   <= b2_ff;
      tx3_ff  <= tx2_ff;
      ty3_ff  <= 59'(typ2_ff) * 59'($signed({1'b0, aspect_ratio}));
      b4_ff   <= b3_ff;
      rx4_ff  <= 42'(tx_r >>> 1);
      ry4_ff  <= 47'(ty_r >>> 13);
      res_ff  <= res_in;
   end

   assign res_valid = v5_ff;
   assign res       = res_ff;

endmodule

FILE: hdl/vfsg_rsp_fifo.sv
// ----------------------------------------------------------------------------
// vfsg_rsp_fifo
// Result queue between the transform pipeline and the result channel.
// ----------------------------------------------------------------------------
module vfsg_rsp_fifo (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   input  vfsg_pkg::rsp_type              push_data,
   input  logic                           pop,
   output logic                           head_valid,
   output vfsg_pkg::rsp_type              head,
   output logic [vfsg_pkg::RSP_CNT_W-1:0] count
);
   import vfsg_pkg::*;

   rsp_type               slot [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [RSP_CNT_W-1:0]  count_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         slot[wr_ptr_ff] <= push_data;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + RSP_PTR_W'(push);
         rd_ptr_ff <= rd_ptr_ff + RSP_PTR_W'(pop);
         count_ff  <= count_ff + RSP_CNT_W'(push) - RSP_CNT_W'(pop);
      end
   end

   assign head_valid = (count_ff != '0);
   assign head       = slot[rd_ptr_ff];
   assign count      = count_ff;

endmodule

FILE: tb/vector_font_stroke_generator_top_test.sv
// ----------------------------------------------------------------------------
// vector_font_stroke_generator_top_test
// Self-checking bench for the stroke font engine. Glyphs are built in the
// table with random content and drawn under a series of rotation, aspect and
// pen settings. A local model predicts every point and cursor report, and
// each result beat is compared field by field, with random request gaps and
// random stalls on the result channel.
// ----------------------------------------------------------------------------
module vector_font_stroke_generator_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   import vfsg_pkg::*;

   localparam int MAX_VECTORS = 63;
   localparam int SPECIAL_LIMIT = 16384;
   localparam logic [1:0] OP_NOOP = 2'd3;
   localparam longint COORD_MAX = 2147483647;
   localparam longint COORD_MIN = -COORD_MAX - 1;
   localparam int DRAIN_CYCLES = 40;
   localparam int LONG_HOLD = 400;
   localparam int WATCHDOG_CYCLES = 4000;
   localparam int PHASE_ITEMS = 30;

   typedef struct {
      logic [1:0]         op;
      logic [12:0]        table_addr;
      logic [15:0]        table_data;
      logic [7:0]         char_code;
      logic signed [31:0] new_x;
      logic signed [31:0] new_y;
      bit                 after_drain;
   } stroke_req_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_op = '0;
   logic [12:0]        req_table_addr = '0;
   logic [15:0]        req_table_data = '0;
   logic [7:0]         req_char_code = '0;
   logic signed [31:0] req_new_x = '0;
   logic signed [31:0] req_new_y = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_point_x;
   logic signed [31:0] rsp_point_y;
   logic               rsp_pen_draw;
   logic               rsp_is_final;
   logic [1:0]         rsp_status;
   logic               rsp_last;
   logic               csr_write = 1'b0;
   logic [1:0]         csr_index = '0;
   logic [31:0]        csr_wdata = '0;

   vector_font_stroke_generator_top #(
      .MAX_VECTORS(MAX_VECTORS)
   ) dut (.*);

   // predicted block state
   logic [15:0]        font_mem [TABLE_WORDS];
   logic signed [31:0] cur_x = '0;
   logic signed [31:0] cur_y = '0;
   logic signed [31:0] cfg_cos = '0;
   logic signed [31:0] cfg_sin = '0;
   logic [15:0]        cfg_aspect = 16'd4096;
   logic               cfg_pen = 1'b1;
   rsp_type            expected_points[$];

   // stimulus plan: mirror of table contents as queued
   logic [15:0]        plan_mem [TABLE_WORDS];
   bit                 plan_written [TABLE_WORDS];
   stroke_req_type     pending_ops[$];
   logic [15:0]        glyph_words[$];

   int  ops_queued = 0;
   int  ops_taken = 0;
   int  stim_count = 0;
   int  failures = 0;
   int  quiet_cycles = 0;
   int  send_gap = 0;
   int  stall_left = 0;
   int  hold_left = 0;
   int  holds_wanted = 0;
   int  holds_done = 0;
   int  mode_left = 0;
   bit  gaps_on = 1'b1;
   bit  calm = 1'b0;
   bit  req_beat = 1'b0;
   bit  rsp_beat = 1'b0;
   bit  load_next;
   stroke_req_type next_req;
   stroke_req_type seen_req;
   rsp_type     want;

   initial begin
      forever #2 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // arithmetic helpers
   // ------------------------------------------------------------------
   function automatic int table_index(input int a);
      return ((a % TABLE_WORDS) + TABLE_WORDS) % TABLE_WORDS;
   endfunction

   function automatic longint round_shr(input longint v, input int n);
      return (v + (longint'(1) <<< (n - 1))) >>> n;
   endfunction

   function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                  input longint b);
      longint s;
      s = longint'(a) + b;
      if (s > COORD_MAX) return 32'sh7fffffff;
      if (s < COORD_MIN) return 32'sh80000000;
      return s[31:0];
   endfunction

   task automatic push_expect(input logic signed [31:0] x, input logic signed [31:0] y,
                              input logic pen, input logic fin, input logic [1:0] st,
                              input logic lst);
      rsp_type p;
      p.point_x = x;
      p.point_y = y;
      p.pen_draw = pen;
      p.is_final = fin;
      p.status = st;
      p.last = lst;
      expected_points.push_back(p);
   endtask

   // ------------------------------------------------------------------
   // stroke prediction for one accepted request
   // ------------------------------------------------------------------
   task automatic predict_stroke(input stroke_req_type r);
      logic [15:0] head, first, w;
      int          hidx, base, count;
      bit          special;
      logic [1:0]  st;
      longint      ix, iy, tx, ty;
      case (r.op)
         OP_WRITE: font_mem[r.table_addr] = r.table_data;
         OP_CURSOR: begin
            cur_x = r.new_x;
            cur_y = r.new_y;
         end
         OP_DRAW: begin
            if (r.char_code < CHAR_FIRST || r.char_code > CHAR_LAST) begin
               push_expect(cur_x, cur_y, 1'b0, 1'b0, STAT_NONPRINT, 1'b1);
            end else begin
               hidx = 2 * (int'(r.char_code) - int'(CHAR_FIRST));
               head = font_mem[hidx];
               special = 1'b0;
               st = STAT_OK;
               if (cfg_pen) begin
                  base = $signed(font_mem[hidx + 1]);
                  first = font_mem[table_index(base)];
                  if ($signed(first) < SPECIAL_LIMIT) begin
                     special = 1'b1;
                  end else begin
                     count = head[7:0];
                     if (count > MAX_VECTORS) begin
                        count = MAX_VECTORS;
                        st = STAT_TRUNC;
                     end
                     for (int k = 0; k < count; k++) begin
                        w = font_mem[table_index(base + k)];
                        ix = longint'($signed(w[13:7]));
                        iy = longint'($signed(w[6:0]));
                        tx = ix * longint'(cfg_cos) - iy * longint'(cfg_sin);
                        ty = (ix * longint'(cfg_sin) + iy * longint'(cfg_cos))
                             * longint'(cfg_aspect);
                        push_expect(sat_add(cur_x, round_shr(tx, 1)),
                                    sat_add(cur_y, round_shr(ty, 13)),
                                    !w[14], 1'b0, STAT_OK, 1'b0);
                     end
                  end
               end
               if (special) begin
                  push_expect(cur_x, cur_y, 1'b0, 1'b0, STAT_SPECIAL, 1'b1);
               end else begin
                  cur_x = sat_add(cur_x,
                     round_shr(longint'(cfg_cos) * longint'(head[15:8]), 1));
                  cur_y = sat_add(cur_y,
                     round_shr(longint'(cfg_sin) * longint'(head[15:8])
                               * longint'(cfg_aspect), 13));
                  push_expect(cur_x, cur_y, 1'b0, 1'b1, st, 1'b1);
               end
            end
         end
         default: ;
      endcase
   endtask

   task automatic check_field(input string name, input logic [31:0] exp_v,
                              input logic [31:0] got_v);
      if (got_v !== exp_v) begin
         $error("%s mismatch: expected %h, actual %h", name, exp_v, got_v);
         failures++;
      end
   endtask

   // ------------------------------------------------------------------
   // monitor: sample both channels at the rising edge
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      req_beat = !reset && req_valid && !req_stall;
      rsp_beat = !reset && rsp_valid && !rsp_stall;
      if (req_beat) begin
         seen_req.op = req_op;
         seen_req.table_addr = req_table_addr;
         seen_req.table_data = req_table_data;
         seen_req.char_code = req_char_code;
         seen_req.new_x = req_new_x;
         seen_req.new_y = req_new_y;
         seen_req.after_drain = 1'b0;
         predict_stroke(seen_req);
         ops_taken++;
      end
      if (rsp_beat) begin
         if (expected_points.size() == 0) begin
            $error("result beat with nothing expected: x %h y %h status %0d",
                   rsp_point_x, rsp_point_y, rsp_status);
            failures++;
         end else begin
            want = expected_points.pop_front();
            check_field("point_x", want.point_x, rsp_point_x);
            check_field("point_y", want.point_y, rsp_point_y);
            check_field("pen_draw", want.pen_draw, rsp_pen_draw);
            check_field("is_final", want.is_final, rsp_is_final);
            check_field("status", want.status, rsp_status);
            check_field("last", want.last, rsp_last);
         end
      end
      if (req_beat || rsp_beat) quiet_cycles = 0;
      else quiet_cycles++;
      // alternate stretches with and without random idling
      if (mode_left == 0) begin
         gaps_on = !gaps_on;
         mode_left = $urandom_range(50, 300);
      end else begin
         mode_left--;
      end
   end

   // ------------------------------------------------------------------
   // request driver
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_beat) begin
            if (gaps_on && !calm && $urandom_range(0, 3) == 0)
               send_gap = $urandom_range(1, 14);
            load_next = 1'b1;
         end else begin
            load_next = !req_valid;
         end
         if (load_next) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_ops.size() > 0 &&
                         (!pending_ops[0].after_drain || expected_points.size() == 0)) begin
               next_req = pending_ops.pop_front();
               req_valid <= 1'b1;
               req_op <= next_req.op;
               req_table_addr <= next_req.table_addr;
               req_table_data <= next_req.table_data;
               req_char_code <= next_req.char_code;
               req_new_x <= next_req.new_x;
               req_new_y <= next_req.new_y;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // result back-pressure
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (holds_done < holds_wanted) begin
         holds_done++;
         hold_left = LONG_HOLD - 1;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (gaps_on && !calm && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 14) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // ------------------------------------------------------------------
   // stimulus construction
   // ------------------------------------------------------------------
   task automatic queue_op(input stroke_req_type r);
      pending_ops.push_back(r);
      ops_queued++;
      if (r.op != OP_NOOP) stim_count++;
   endtask

   function automatic stroke_req_type blank_req(input logic [1:0] op);
      stroke_req_type r;
      r.op = op;
      r.table_addr = 13'($urandom);
      r.table_data = 16'($urandom);
      r.char_code = 8'($urandom);
      r.new_x = $urandom;
      r.new_y = $urandom;
      r.after_drain = 1'b0;
      return r;
   endfunction

   task automatic queue_write(input int addr, input logic [15:0] data);
      stroke_req_type r;
      r = blank_req(OP_WRITE);
      r.table_addr = 13'(addr);
      r.table_data = data;
      plan_mem[addr] = data;
      plan_written[addr] = 1'b1;
      queue_op(r);
   endtask

   task automatic queue_cursor(input logic [31:0] x, input logic [31:0] y);
      stroke_req_type r;
      r = blank_req(OP_CURSOR);
      r.new_x = x;
      r.new_y = y;
      queue_op(r);
   endtask

   task automatic queue_draw(input logic [7:0] code, input bit drain_first);
      stroke_req_type r;
      r = blank_req(OP_DRAW);
      r.char_code = code;
      r.after_drain = drain_first;
      queue_op(r);
   endtask

   // vector words first, header and offset last so the header survives
   task automatic write_glyph(input logic [7:0] code, input logic [7:0] nvec,
                              input logic [7:0] gap, input logic signed [15:0] ofs,
                              input logic [15:0] words[$]);
      int hidx;
      hidx = 2 * (int'(code) - int'(CHAR_FIRST));
      for (int k = 0; k < words.size(); k++)
         queue_write(table_index(int'(ofs) + k), words[k]);
      queue_write(hidx, {gap, nvec});
      queue_write(hidx + 1, ofs);
   endtask

   // every word a draw of this code would read has been written
   function automatic bit glyph_ready(input logic [7:0] code);
      int hidx, base, n;
      hidx = 2 * (int'(code) - int'(CHAR_FIRST));
      if (!plan_written[hidx] || !plan_written[hidx + 1]) return 1'b0;
      base = $signed(plan_mem[hidx + 1]);
      n = plan_mem[hidx][7:0];
      if (n > MAX_VECTORS) n = MAX_VECTORS;
      if (n < 1) n = 1;
      for (int k = 0; k < n; k++)
         if (!plan_written[table_index(base + k)]) return 1'b0;
      return 1'b1;
   endfunction

   function automatic int pick_count();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75) return $urandom_range(0, 6);
      if (r < 93) return $urandom_range(7, 40);
      return $urandom_range(MAX_VECTORS, 255);
   endfunction

   task automatic build_glyph(input logic [7:0] code, input int nvec, input bit allow_special);
      logic [15:0]        words[$];
      logic signed [15:0] ofs;
      int                 n, anchor, fold;
      n = nvec > MAX_VECTORS ? MAX_VECTORS : (nvec < 1 ? 1 : nvec);
      if (allow_special && $urandom_range(0, 9) == 0)
         words.push_back($urandom_range(0, 1) ? {1'b1, 15'($urandom)} : {2'b00, 14'($urandom)});
      else
         words.push_back({2'b01, 14'($urandom)});
      for (int k = 1; k < n; k++) words.push_back(16'($urandom));
      anchor = ($urandom_range(0, 19) == 0) ? $urandom_range(8150, 8191)
                                            : $urandom_range(256, 8120);
      // offsets beyond the table and negative ones wrap onto the same words
      fold = int'($urandom_range(0, 7)) - 4;
      ofs = 16'(anchor + TABLE_WORDS * fold);
      write_glyph(code, 8'(nvec), 8'($urandom), ofs, words);
   endtask

   function automatic logic [31:0] pick_coord();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 32'h7fffffff;
      if (r == 1) return 32'h80000000;
      if (r < 6) return $urandom;
      return $urandom_range(0, 32'h2000_0000) - 32'h1000_0000;
   endfunction

   function automatic logic [31:0] modest_gain();
      return $urandom_range(0, 32'h4000_0000) - 32'h2000_0000;
   endfunction

   task automatic run_phase(input int n, input int drain_odds);
      int             target, sel;
      logic [7:0]     code;
      stroke_req_type r;
      target = stim_count + n;
      while (stim_count < target) begin
         sel = $urandom_range(0, 99);
         if (sel < 55) begin
            code = $urandom_range(int'(CHAR_FIRST), int'(CHAR_LAST));
            if (sel >= 40 || !glyph_ready(code)) build_glyph(code, pick_count(), 1'b1);
            queue_draw(code, $urandom_range(0, 19) < drain_odds);
         end else if (sel < 65) begin
            code = $urandom_range(0, 1) ? $urandom_range(0, int'(CHAR_FIRST) - 1)
                                        : $urandom_range(int'(CHAR_LAST) + 1, 255);
            queue_draw(code, 1'b0);
         end else if (sel < 78) begin
            queue_cursor(pick_coord(), pick_coord());
         end else if (sel < 92) begin
            // stray table write, may clobber a glyph
            queue_write($urandom_range(0, TABLE_WORDS - 1), 16'($urandom));
         end else begin
            r = blank_req(OP_NOOP);
            queue_op(r);
         end
      end
   endtask

   // ------------------------------------------------------------------
   // register access, only while the block is idle
   // ------------------------------------------------------------------
   task automatic csr_put(input logic [1:0] idx, input logic [31:0] v);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      case (idx)
         CSR_ROT_COS: cfg_cos = v;
         CSR_ROT_SIN: cfg_sin = v;
         CSR_ASPECT:  cfg_aspect = v[15:0];
         CSR_PEN:     cfg_pen = v[0];
         default: ;
      endcase
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic configure(input logic [31:0] c, input logic [31:0] s,
                            input logic [15:0] asp, input logic pen);
      csr_put(CSR_ROT_COS, c);
      csr_put(CSR_ROT_SIN, s);
      csr_put(CSR_ASPECT, {16'($urandom), asp});
      csr_put(CSR_PEN, {31'($urandom), pen});
   endtask

   task automatic wait_idle();
      while (ops_taken != ops_queued || expected_points.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // ------------------------------------------------------------------
   // test sequence
   // ------------------------------------------------------------------
   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      configure(32'h2000_0000, 32'h1000_0000, 16'd4096, 1'b1);
      @(posedge clock);

      // nonprintable codes at both edges of the printable range
      queue_draw(8'd0, 1'b0);
      queue_draw(CHAR_FIRST - 8'd1, 1'b0);
      queue_draw(CHAR_LAST + 8'd1, 1'b0);
      queue_draw(8'd255, 1'b0);
      // extreme vector offsets, move and draw flags
      glyph_words = {16'h5fbf, 16'h2040, 16'h3fff, 16'hffff};
      write_glyph(8'd65, 8'd4, 8'd255, 16'sd1000, glyph_words);
      queue_draw(8'd65, 1'b0);
      queue_cursor(32'h7fffffff, 32'h7fffffff);
      queue_draw(8'd65, 1'b0);
      queue_cursor(32'h80000000, 32'h80000000);
      queue_draw(8'd65, 1'b0);
      // special glyphs: first word just below the limit, and negative
      glyph_words = {16'h3fff, 16'h1234, 16'h4321};
      write_glyph(CHAR_FIRST, 8'd3, 8'd10, 16'sd2000, glyph_words);
      queue_draw(CHAR_FIRST, 1'b0);
      glyph_words = {16'h8000};
      write_glyph(CHAR_LAST, 8'd1, 8'd200, -16'sd3000, glyph_words);
      queue_draw(CHAR_LAST, 1'b0);
      queue_cursor(32'h0123_4567, 32'hfedc_ba98);
      queue_draw(8'd65, 1'b0);

      for (int p = 1; p <= 7; p++) begin
         wait_idle();
         case (p)
            1: configure(32'h7fffffff, 32'h80000000, 16'hffff, 1'b1);
            2: configure($urandom, $urandom, 16'($urandom), 1'b1);
            3: configure(32'h80000000, 32'h7fffffff, 16'd0, 1'b1);
            4: configure($urandom, $urandom, 16'($urandom), 1'b0);
            5: configure(modest_gain(), modest_gain(), 16'($urandom_range(2048, 8192)), 1'b1);
            6: configure(32'd0, 32'd0, 16'd4096, 1'b1);
            default: configure(modest_gain(), modest_gain(), 16'($urandom), 1'b1);
         endcase
         @(posedge clock);
         case (p)
            1: begin
               // hold results back long enough to fill the block
               holds_wanted++;
               build_glyph(8'd87, MAX_VECTORS + 1, 1'b0);
               queue_draw(8'd87, 1'b0);
            end
            2: begin
               build_glyph(8'd70, pick_count(), 1'b0);
               queue_draw(8'd70, 1'b0);
               queue_draw(8'd70, 1'b1);
            end
            3: begin
               build_glyph(8'd88, MAX_VECTORS, 1'b0);
               queue_draw(8'd88, 1'b0);
            end
            7: calm = 1'b1;
            default: ;
         endcase
         run_phase(PHASE_ITEMS, p == 2 ? 4 : 1);
      end

      wait_idle();
      if (failures == 0) begin
         $display("vector_font_stroke_generator_top_test passed");
      end else begin
         $display("vector_font_stroke_generator_top_test failed");
      end
      $finish;
   end

   initial begin
      wait (quiet_cycles >= WATCHDOG_CYCLES);
      $display("vector_font_stroke_generator_top_test failed");
      $finish;
   end

endmodule

FILE: sim.f
hdl/vfsg_pkg.sv
hdl/vfsg_seq.sv
hdl/vfsg_xform.sv
hdl/vfsg_rsp_fifo.sv
hdl/vector_font_stroke_generator_top.sv
tb/vector_font_stroke_generator_top_test.sv
